### src/slcg_pkg.sv
// shared constants, controller states and control structs for the seeded random draw unit
package slcg_pkg;

    localparam logic [31:0] LCG_MUL    = 32'd214013;
    localparam logic [31:0] LCG_ADD    = 32'd2531011;
    localparam int          DRAW_W     = 15;
    localparam int          DRAW_LSB   = 16;
    localparam logic [14:0] DRAW_LIMIT = 15'h7fff;
    localparam logic [3:0]  DIV_LAST   = 4'd14;
    localparam logic        KIND_SCALE  = 1'b0;
    localparam logic        KIND_BOUNDS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SPAN,
        S_MUL,
        S_ADV,
        S_DIV,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic check;
        logic span;
        logic mul;
        logic adv;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

### src/slcg_ctrl.sv
// controller state machine sequencing one request through the datapath
module slcg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  slcg_pkg::t_status i_status,
    output slcg_pkg::t_cmd    o_cmd
);

    slcg_pkg::t_state r_state;
    slcg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slcg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            slcg_pkg::S_IDLE: begin
                if (i_req_valid) n_state = slcg_pkg::S_CHECK;
            end
            slcg_pkg::S_CHECK: begin
                n_state = slcg_pkg::S_SPAN;
            end
            slcg_pkg::S_SPAN: begin
                n_state = i_status.skip ? slcg_pkg::S_FINISH : slcg_pkg::S_MUL;
            end
            slcg_pkg::S_MUL: begin
                n_state = slcg_pkg::S_ADV;
            end
            slcg_pkg::S_ADV: begin
                n_state = slcg_pkg::S_DIV;
            end
            slcg_pkg::S_DIV: begin
                if (i_status.div_last) n_state = slcg_pkg::S_FINISH;
            end
            slcg_pkg::S_FINISH: begin
                if (i_status.out_free) n_state = slcg_pkg::S_IDLE;
            end
            default: begin
                n_state = slcg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            slcg_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            slcg_pkg::S_CHECK:  o_cmd.check    = 1'b1;
            slcg_pkg::S_SPAN:   o_cmd.span     = 1'b1;
            slcg_pkg::S_MUL:    o_cmd.mul      = 1'b1;
            slcg_pkg::S_ADV:    o_cmd.adv      = 1'b1;
            slcg_pkg::S_DIV:    o_cmd.div_step = 1'b1;
            slcg_pkg::S_FINISH: o_cmd.finish   = i_status.out_free;
            default: begin
                o_cmd       = '0;
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

### src/slcg_dp.sv
// datapath: generator state, operand ordering, span clamp, bit-serial modulo, output register
module slcg_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slcg_pkg::t_cmd    i_cmd,
    output slcg_pkg::t_status o_status,
    input  logic              i_kind,
    input  logic [30:0]       i_scale,
    input  logic [31:0]       i_low_bound,
    input  logic [31:0]       i_high_bound,
    input  logic              i_seed_wr_en,
    input  logic [31:0]       i_seed_wr_data,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [31:0]       o_value
);

    logic [31:0] r_gen_state;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic        r_kind;
    logic [30:0] r_scale;
    logic [31:0] r_lo;
    logic [31:0] r_hi;
    logic [31:0] r_lower;
    logic [31:0] r_upper;
    logic        r_skip;
    logic [14:0] r_divisor;
    logic [31:0] r_prod;
    logic [14:0] r_dividend;
    logic [14:0] r_rem;
    logic [3:0]  r_bit_cnt;

    logic        swap;
    logic [32:0] diff;
    logic [31:0] n_gen_state;
    logic [15:0] trial;
    logic [14:0] n_rem;
    logic        out_free;

    assign swap        = $signed(r_lo) > $signed(r_hi);
    assign diff        = {r_upper[31], r_upper} - {r_lower[31], r_lower};
    assign n_gen_state = r_prod + slcg_pkg::LCG_ADD;
    assign trial       = {r_rem, r_dividend[14]};
    assign n_rem       = (trial >= {1'b0, r_divisor}) ? 15'(trial - {1'b0, r_divisor})
                                                      : trial[14:0];
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_status.skip     = r_skip;
    assign o_status.div_last = (r_bit_cnt == slcg_pkg::DIV_LAST);
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_value           = r_out_data;

    // generator state and output valid carry reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_state <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_seed_wr_en) begin
                r_gen_state <= i_seed_wr_data;
            end else if (i_cmd.adv) begin
                r_gen_state <= n_gen_state;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_scale <= i_scale;
            r_lo    <= i_low_bound;
            r_hi    <= i_high_bound;
        end
        if (i_cmd.check) begin
            r_rem <= '0;
            if (r_kind == slcg_pkg::KIND_SCALE) begin
                r_skip    <= !((r_scale > 31'd1) && (r_scale <= 31'(slcg_pkg::DRAW_LIMIT)));
                r_divisor <= r_scale[14:0];
                r_lower   <= '0;
                r_upper   <= '0;
            end else begin
                r_skip    <= (r_lo == r_hi);
                r_divisor <= slcg_pkg::DRAW_LIMIT;
                r_lower   <= swap ? r_hi : r_lo;
                r_upper   <= swap ? r_lo : r_hi;
            end
        end
        // span is upper - lower + 1, clamped to the draw range
        if (i_cmd.span && (r_kind == slcg_pkg::KIND_BOUNDS)) begin
            if (diff >= 33'(slcg_pkg::DRAW_LIMIT) - 33'd1) begin
                r_divisor <= slcg_pkg::DRAW_LIMIT;
            end else begin
                r_divisor <= diff[14:0] + 15'd1;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= r_gen_state * slcg_pkg::LCG_MUL;
        end
        if (i_cmd.adv) begin
            r_dividend <= n_gen_state[slcg_pkg::DRAW_LSB +: slcg_pkg::DRAW_W];
            r_rem      <= '0;
            r_bit_cnt  <= '0;
        end
        // restoring modulo, one dividend bit per cycle
        if (i_cmd.div_step) begin
            r_rem      <= n_rem;
            r_dividend <= {r_dividend[13:0], 1'b0};
            r_bit_cnt  <= r_bit_cnt + 4'd1;
        end
        if (i_cmd.finish) begin
            r_out_data <= (r_kind == slcg_pkg::KIND_BOUNDS) ? r_lower + {17'd0, r_rem}
                                                            : {17'd0, r_rem};
        end
    end

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_divisor))
        else $error("remainder not below divisor");

    a_div_nontrivial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_divisor >= 15'd2))
        else $error("modulo started with divisor below two");

    a_seed_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seed_wr_en |=> (r_gen_state == $past(i_seed_wr_data)))
        else $error("seed write not loaded into generator state");

    a_finish_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> out_free)
        else $error("result written over a pending result");

    a_skip_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.span && r_skip) |=> !i_cmd.mul)
        else $error("generator stepped on a rejected request");

endmodule

### src/seeded_lcg_random_in_range_unit.sv
// top level of the seeded random draw unit: controller, datapath and stream ports
// When a draw is made, each request goes from acceptance to the result register through the
// operand check, span clamp, the 32x18 generator multiply, the state add, then a restoring
// modulo over the 15 draw bits that retires one draw bit per cycle; rejected scales and equal
// bounds skip the draw and finish without stepping the generator. One request is worked at a
// time; the result register lets a new request enter while the previous result waits. Writing
// i_seed_wr_data with i_seed_wr_en loads the generator state directly (reset state is zero).
module seeded_lcg_random_in_range_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_wr_en,
    input  logic [31:0] i_seed_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // scale[30:0], low_bound[62:31], high_bound[94:63], pad
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // value
);

    slcg_pkg::t_cmd    cmd;
    slcg_pkg::t_status status;

    slcg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    slcg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_kind         (s_axis_tuser),
        .i_scale        (s_axis_tdata[30:0]),
        .i_low_bound    (s_axis_tdata[62:31]),
        .i_high_bound   (s_axis_tdata[94:63]),
        .i_seed_wr_en   (i_seed_wr_en),
        .i_seed_wr_data (i_seed_wr_data),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_value        (m_axis_tdata)
    );

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the seeded random draw unit, with a built-in generator predictor
module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_seed_wr_en;
    logic [31:0] i_seed_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // scale[30:0], low_bound[62:31], high_bound[94:63], pad
    logic        s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // value

    logic [31:0] lcg_state;
    logic [31:0] pending_values[$];
    int          mismatch_count;
    bit          tx_idle_on;
    bit          rx_idle_on;
    int          rx_hold_cycles;

    seeded_lcg_random_in_range_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_wr_en   (i_seed_wr_en),
        .i_seed_wr_data (i_seed_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #500000;
        $display("FAILURE");
        $finish;
    end

    // steps the generator and returns the 15-bit draw
    function automatic longint advance_lcg();
        lcg_state = lcg_state * slcg_pkg::LCG_MUL + slcg_pkg::LCG_ADD;
        return longint'(lcg_state[slcg_pkg::DRAW_LSB +: slcg_pkg::DRAW_W]);
    endfunction

    function automatic logic [31:0] next_random_value(input logic kind,
            input logic [30:0] scale, input logic [31:0] low_bound,
            input logic [31:0] high_bound);
        longint lower;
        longint upper;
        longint span;
        longint draw;
        if (kind == slcg_pkg::KIND_SCALE) begin
            if (scale < 2 || scale > slcg_pkg::DRAW_LIMIT)
                return '0;
            draw = advance_lcg();
            return 32'(draw % scale);
        end
        if (low_bound == high_bound)
            return low_bound;
        lower = longint'($signed(low_bound));
        upper = longint'($signed(high_bound));
        if (lower > upper) begin
            span  = lower;
            lower = upper;
            upper = span;
        end
        span = upper - lower + 1;
        if (span > slcg_pkg::DRAW_LIMIT)
            span = slcg_pkg::DRAW_LIMIT;
        draw = advance_lcg();
        return 32'(lower + draw % span);
    endfunction

    task automatic send_request(input logic kind, input logic [30:0] scale,
                                input logic [31:0] low_bound, input logic [31:0] high_bound);
        int          gap;
        logic [31:0] expected;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tdata  <= {1'b0, high_bound, low_bound, scale};
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected       = next_random_value(kind, scale, low_bound, high_bound);
        pending_values = {pending_values, expected};
    endtask

    task automatic send_random_request();
        logic        kind;
        logic [30:0] scale;
        logic [31:0] low_bound;
        logic [31:0] high_bound;
        int          pick;
        kind = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick < 3)
            scale = 31'($urandom_range(2, 100));
        else if (pick < 6)
            scale = 31'($urandom_range(2, 32767));
        else if (pick == 6)
            scale = 31'($urandom_range(0, 1));
        else if (pick == 7)
            scale = 31'($urandom_range(32768, 40000));
        else
            scale = 31'($urandom);
        low_bound = $urandom;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            high_bound = low_bound;
        else if (pick < 5)
            high_bound = low_bound + 32'($urandom_range(0, 70000)) - 32'd35000;
        else if (pick < 7)
            high_bound = low_bound + 32'($urandom_range(1, 40));
        else if (pick == 7) begin
            // spans that reach the signed extremes
            low_bound  = 32'h8000_0000 + 32'($urandom_range(0, 20));
            high_bound = 32'h7fff_ffff - 32'($urandom_range(0, 20));
        end else
            high_bound = $urandom;
        send_request(kind, scale, low_bound, high_bound);
    endtask

    // waits until every result is back and the unit has gone quiet
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (25) @(negedge i_clk);
    endtask

    task automatic load_seed(input logic [31:0] seed);
        drain_results();
        i_seed_wr_en   <= 1'b1;
        i_seed_wr_data <= seed;
        lcg_state = seed;
        @(negedge i_clk);
        i_seed_wr_en   <= 1'b0;
    endtask

    task automatic test_reset_state();
        tx_idle_on = 1'b1;
        send_request(slcg_pkg::KIND_SCALE, 31'd32767, 32'd0, 32'd0);
        send_request(slcg_pkg::KIND_BOUNDS, 31'd0, 32'd10, 32'd20);
    endtask

    task automatic test_scale_edges();
        send_request(slcg_pkg::KIND_SCALE, 31'd0, $urandom, $urandom);
        send_request(slcg_pkg::KIND_SCALE, 31'd1, $urandom, $urandom);
        send_request(slcg_pkg::KIND_SCALE, 31'd2, $urandom, $urandom);
        send_request(slcg_pkg::KIND_SCALE, 31'd32767, 32'hffff_ffff, 32'h0);
        send_request(slcg_pkg::KIND_SCALE, 31'd32768, 32'd0, 32'd0);
        send_request(slcg_pkg::KIND_SCALE, 31'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_request(slcg_pkg::KIND_SCALE, 31'd1000, 32'd5, 32'd5);
    endtask

    task automatic test_bound_cases();
        send_request(slcg_pkg::KIND_BOUNDS, 31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_request(slcg_pkg::KIND_BOUNDS, 31'd0, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request(slcg_pkg::KIND_BOUNDS, 31'd5, 32'd0, 32'd0);
        // reversed order
        send_request(slcg_pkg::KIND_BOUNDS, 31'd0, 32'd100, 32'hffff_ff9c);
        send_request(slcg_pkg::KIND_BOUNDS, 31'd0, 32'h8000_0000, 32'h7fff_ffff);
        send_request(slcg_pkg::KIND_BOUNDS, 31'd0, 32'h7fff_ffff, 32'h8000_0000);
        // span of exactly the draw limit, and one past it
        send_request(slcg_pkg::KIND_BOUNDS, 31'd0, 32'd0, 32'd32766);
        send_request(slcg_pkg::KIND_BOUNDS, 31'd0, 32'hffff_fff0, 32'd32751);
        send_request(slcg_pkg::KIND_BOUNDS, 31'd0, 32'hffff_fffe, 32'hffff_ffff);
        send_request(slcg_pkg::KIND_BOUNDS, 31'd0, 32'h7fff_fffe, 32'h7fff_ffff);
    endtask

    task automatic test_seed_settings();
        logic [31:0] seeds[5];
        seeds = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h1, $urandom};
        foreach (seeds[k]) begin
            load_seed(seeds[k]);
            repeat (8) send_random_request();
        end
    endtask

    task automatic test_backpressure();
        drain_results();
        tx_idle_on     = 1'b0;
        rx_hold_cycles = 300;
        repeat (24) send_random_request();
        tx_idle_on     = 1'b1;
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            load_seed(phase == 5 ? 32'hffff_ffff : $urandom);
            tx_idle_on = (phase % 3) != 1 && phase != 5;
            rx_idle_on = (phase % 3) != 2 && phase != 5;
            repeat (105) send_random_request();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // result side: random stall per result, plus a long hold when asked
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                rx_hold_cycles = 0;
            end
            stall = rx_idle_on ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                if (m_axis_tdata !== pending_values[0]) begin
                    $display("%0t: value mismatch, expected %h, actual %h",
                             $time, pending_values[0], m_axis_tdata);
                    mismatch_count++;
                end
                void'(pending_values.pop_front());
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_seed_wr_en   = 1'b0;
        i_seed_wr_data = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        lcg_state      = '0;
        mismatch_count = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_scale_edges();
        test_bound_cases();
        test_seed_settings();
        test_backpressure();
        test_random_traffic();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### seeded_lcg_random_in_range_unit.f
src/slcg_pkg.sv
src/slcg_ctrl.sv
src/slcg_dp.sv
src/seeded_lcg_random_in_range_unit.sv
tb/sv/testbench.sv
